// File: rtl/core/six_register_machine_step_macros.svh
// Assertion macros for the six-register machine step block.
// Used by the checker; expects i_clk and i_rst_n in the enclosing scope.
`ifndef SIX_REGISTER_MACHINE_STEP_MACROS_SVH
`define SIX_REGISTER_MACHINE_STEP_MACROS_SVH

// Checked only outside reset.
`define SRMS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("six_register_machine_step check failed");

// Checked on every edge, reset included.
`define SRMS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("six_register_machine_step check failed");

`endif

// File: rtl/core/srms_pkg.sv
// Shared types and constants for the six-register machine step block.
// No dependencies; imported by the top level and its checker.
package srms_pkg;

    localparam int REG_COUNT  = 6;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int DATA_W     = 32;
    localparam int OPCODE_W   = 4;
    localparam int IP_REG_W   = 3;
    localparam int PROG_LEN_W = 16;
    localparam int DEST_W     = 3;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IP_REGISTER    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = CFG_IDX_W'(1);

    localparam logic [PROG_LEN_W-1:0] PROG_LEN_RESET = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADDR = 4'd0,  OP_ADDI = 4'd1,  OP_MULR = 4'd2,  OP_MULI = 4'd3,
        OP_BANR = 4'd4,  OP_BANI = 4'd5,  OP_BORR = 4'd6,  OP_BORI = 4'd7,
        OP_SETR = 4'd8,  OP_SETI = 4'd9,  OP_GTIR = 4'd10, OP_GTRI = 4'd11,
        OP_GTRR = 4'd12, OP_EQIR = 4'd13, OP_EQRI = 4'd14, OP_EQRR = 4'd15
    } t_opcode;

    // One instruction as packed on the input tdata (opcode in the low bits)
    typedef struct packed {
        logic [DEST_W-1:0] dest_reg;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] operand_a;
        t_opcode           opcode;
    } t_instr;

    localparam int INSTR_W = $bits(t_instr);

endpackage

// File: rtl/core/six_register_machine_step.sv
// Top level of the six-register machine step block.
// Depends on srms_pkg (types, opcodes, widths).
//
// Executes one instruction of a six-register, 32-bit machine per input
// transaction and returns one result transaction per instruction. An input
// transaction is captured into an instruction register; when the result
// register is free or being emptied, the register file is read (with the
// mirror register already showing the instruction pointer), the ALU runs,
// the register file and pointer are updated and the result register is
// loaded. The block sustains one instruction per clock while results are
// taken: throughput is set by the read/ALU/write-back path around the
// register file, which also makes each instruction see all writes of the
// one before it. Input is taken while a finished result still waits, as
// long as the instruction register can move on. The 32x32 multiply keeps
// the low 32 bits. A register index above 5 on a used operand or on the
// destination sets the bad-index flag (tuser), writes nothing and reports
// a written value of zero; the pointer still advances. tlast marks a
// result whose next pointer is at or beyond the configured program length;
// it is a flag only and execution carries on. The user must write the
// configuration (mirror register index, program length) through the plain
// write port only while the block is idle; the block does not enforce it.
module six_register_machine_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input instruction stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] opcode, [35:4] operand_a, [67:36] operand_b, [70:68] dest_reg
    input  logic [srms_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] next_ip, [34:32] dest_index, [66:35] written_value
    output logic [srms_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,   // halted
    output logic                               m_axis_tuser,   // bad_index
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [srms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srms_pkg::*;

    // instruction register
    logic                  r_in_valid;
    t_instr                r_instr;

    // machine state
    logic [DATA_W-1:0]     r_regs [REG_COUNT];
    logic [DATA_W-1:0]     r_ip;
    logic [IP_REG_W-1:0]   r_ip_register;
    logic [PROG_LEN_W-1:0] r_prog_len;

    // result register
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_next_ip;
    logic [DEST_W-1:0]     r_dest_index;
    logic [DATA_W-1:0]     r_written_value;
    logic                  r_halted;
    logic                  r_bad_index;

    // execute stage
    logic                  exec;
    logic                  accept;
    logic                  mirror;
    logic [REG_IDX_W-1:0]  ip_sel;
    logic [DATA_W-1:0]     eff_regs [REG_COUNT];
    logic                  a_is_reg, b_is_reg;
    logic                  a_ok, b_ok, dest_ok;
    logic [REG_IDX_W-1:0]  a_idx, b_idx, dest_idx;
    logic [DATA_W-1:0]     val_a, val_b;
    logic [DATA_W-1:0]     src_a, src_b;
    logic [DATA_W-1:0]     alu_res;
    logic                  bad;
    logic [DATA_W-1:0]     n_written_value;
    logic                  wr_ip_reg;
    logic [DATA_W-1:0]     n_next_ip;

    // Instruction register moves on when the result register is free or
    // is being emptied this cycle.
    assign exec          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || exec;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // --- register read with pointer mirror ---
    assign mirror = int'(r_ip_register) < REG_COUNT;
    assign ip_sel = REG_IDX_W'(r_ip_register);

    always_comb begin
        for (int i = 0; i < REG_COUNT; i++) begin
            eff_regs[i] = (mirror && ip_sel == REG_IDX_W'(i)) ? r_ip : r_regs[i];
        end
    end

    assign a_ok     = r_instr.operand_a < DATA_W'(REG_COUNT);
    assign b_ok     = r_instr.operand_b < DATA_W'(REG_COUNT);
    assign dest_ok  = int'(r_instr.dest_reg) < REG_COUNT;
    assign a_idx    = REG_IDX_W'(r_instr.operand_a);
    assign b_idx    = REG_IDX_W'(r_instr.operand_b);
    assign dest_idx = REG_IDX_W'(r_instr.dest_reg);

    // read ports as per-entry selects; out-of-range reads give zero
    always_comb begin
        val_a = '0;
        val_b = '0;
        for (int i = 0; i < REG_COUNT; i++) begin
            if (a_ok && a_idx == REG_IDX_W'(i)) begin
                val_a = eff_regs[i];
            end
            if (b_ok && b_idx == REG_IDX_W'(i)) begin
                val_b = eff_regs[i];
            end
        end
    end

    // --- operand decode ---
    always_comb begin
        case (r_instr.opcode) inside
            OP_ADDR, OP_ADDI, OP_MULR, OP_MULI, OP_BANR, OP_BANI, OP_BORR,
            OP_BORI, OP_SETR, OP_GTRI, OP_GTRR, OP_EQRI, OP_EQRR: a_is_reg = 1'b1;
            default:                                               a_is_reg = 1'b0;
        endcase
        case (r_instr.opcode) inside
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR,
            OP_EQIR, OP_EQRR: b_is_reg = 1'b1;
            default:          b_is_reg = 1'b0;
        endcase
    end

    assign src_a = a_is_reg ? val_a : r_instr.operand_a;
    assign src_b = b_is_reg ? val_b : r_instr.operand_b;
    assign bad   = (a_is_reg && !a_ok) || (b_is_reg && !b_ok) || !dest_ok;

    // --- ALU ---
    always_comb begin
        case (r_instr.opcode) inside
            OP_ADDR, OP_ADDI: alu_res = src_a + src_b;
            OP_MULR, OP_MULI: alu_res = src_a * src_b;   // low 32 bits kept
            OP_BANR, OP_BANI: alu_res = src_a & src_b;
            OP_BORR, OP_BORI: alu_res = src_a | src_b;
            OP_SETR:          alu_res = src_a;
            OP_SETI:          alu_res = r_instr.operand_a;
            OP_GTIR, OP_GTRI, OP_GTRR: alu_res = DATA_W'(src_a > src_b);
            default:          alu_res = DATA_W'(src_a == src_b);
        endcase
    end

    assign n_written_value = bad ? '0 : alu_res;

    // pointer follows the mirror register, which the write may have hit
    assign wr_ip_reg = mirror && !bad && dest_idx == ip_sel;
    assign n_next_ip = (wr_ip_reg ? n_written_value : r_ip) + DATA_W'(1);

    // --- instruction register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_instr <= t_instr'(s_axis_tdata[INSTR_W-1:0]);
        end
    end

    // --- machine state and configuration ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
            r_ip          <= '0;
            r_ip_register <= '0;
            r_prog_len    <= PROG_LEN_RESET;
        end else begin
            if (exec) begin
                for (int i = 0; i < REG_COUNT; i++) begin
                    if (!bad && dest_idx == REG_IDX_W'(i)) begin
                        r_regs[i] <= n_written_value;
                    end else if (mirror && ip_sel == REG_IDX_W'(i)) begin
                        r_regs[i] <= r_ip;
                    end
                end
                r_ip <= n_next_ip;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IP_REGISTER:    r_ip_register <= i_cfg_data[IP_REG_W-1:0];
                    CFG_PROGRAM_LENGTH: r_prog_len    <= i_cfg_data[PROG_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // --- result register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (exec) begin
            r_next_ip       <= n_next_ip;
            r_dest_index    <= r_instr.dest_reg;
            r_written_value <= n_written_value;
            r_halted        <= n_next_ip >= DATA_W'(r_prog_len);
            r_bad_index     <= bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_written_value, r_dest_index, r_next_ip});
    assign m_axis_tlast  = r_halted;
    assign m_axis_tuser  = r_bad_index;

endmodule

// File: rtl/core/srms_checker.sv
// Port-level checker for the six-register machine step block, with bind.
// Depends on srms_pkg and six_register_machine_step_macros.svh.
`include "six_register_machine_step_macros.svh"

module srms_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [srms_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tlast,
    input  logic                               m_axis_tuser
);
    import srms_pkg::*;

    // no result straight after reset
    `SRMS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid)

    // a stalled result holds
    `SRMS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // input only backs up when a result is waiting
    `SRMS_ASSERT(a_no_idle_stall, !s_axis_tready |-> m_axis_tvalid)

    // an invalid destination is always flagged
    `SRMS_ASSERT(a_bad_dest, m_axis_tvalid && int'(m_axis_tdata[34:32]) >= REG_COUNT |-> m_axis_tuser)

    // flagged instructions report nothing written
    `SRMS_ASSERT(a_bad_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[66:35] == '0)

endmodule

bind six_register_machine_step srms_checker u_srms_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the six-register machine step block.
// Depends on srms_pkg and six_register_machine_step; needs nothing else.
`timescale 1ns / 100ps

module tb_top;
    import srms_pkg::*;

    // Runaway guard. The slowest legal run is about 1.5k transactions, each with
    // random idling on either side, plus one long hold-off and the drains.
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the block
    localparam int PHASE_ITEMS  = 250;  // random instructions per phase
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE       = 8;    // cycles after the last result

    // One expected result transaction
    typedef struct packed {
        logic [DATA_W-1:0] next_ip;
        logic [DEST_W-1:0] dest_index;
        logic [DATA_W-1:0] written_value;
        logic              halted;
        logic              bad_index;
    } t_retire;

    // Shadow of the machine: register file, pointer and configuration.
    // issue() runs one accepted instruction and queues what must come out;
    // retire() checks one result transaction against the oldest entry.
    class retire_tracker;
        logic [DATA_W-1:0]     gpr [REG_COUNT];
        logic [DATA_W-1:0]     ip;
        logic [IP_REG_W-1:0]   mirror_sel;
        logic [PROG_LEN_W-1:0] prog_len;
        t_retire               retirements [$];
        int                    fail_count;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            ip         = '0;
            mirror_sel = '0;
            prog_len   = PROG_LEN_RESET;
            fail_count = 0;
        endfunction

        function void set_mirror(logic [IP_REG_W-1:0] sel);
            mirror_sel = sel;
        endfunction

        function void set_length(logic [PROG_LEN_W-1:0] len);
            prog_len = len;
        endfunction

        function void issue(t_instr ins);
            logic [DATA_W-1:0] ra;
            logic [DATA_W-1:0] rb;
            logic [DATA_W-1:0] val;
            logic [DATA_W-1:0] nip;
            logic              a_is_reg;
            logic              b_is_reg;
            logic              bad;
            logic              mirror;
            t_retire           r;

            mirror = (mirror_sel < REG_COUNT);
            if (mirror) gpr[mirror_sel] = ip;

            // immediate and ignored operands are never range-checked
            a_is_reg = !(ins.opcode inside {OP_SETI, OP_GTIR, OP_EQIR});
            b_is_reg = ins.opcode inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
                                          OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
            ra  = (ins.operand_a < REG_COUNT) ? gpr[ins.operand_a[2:0]] : '0;
            rb  = (ins.operand_b < REG_COUNT) ? gpr[ins.operand_b[2:0]] : '0;
            bad = (a_is_reg && ins.operand_a >= REG_COUNT)
               || (b_is_reg && ins.operand_b >= REG_COUNT)
               || (ins.dest_reg >= REG_COUNT);

            case (ins.opcode)
                OP_ADDR: val = ra + rb;
                OP_ADDI: val = ra + ins.operand_b;
                OP_MULR: val = ra * rb;
                OP_MULI: val = ra * ins.operand_b;
                OP_BANR: val = ra & rb;
                OP_BANI: val = ra & ins.operand_b;
                OP_BORR: val = ra | rb;
                OP_BORI: val = ra | ins.operand_b;
                OP_SETR: val = ra;
                OP_SETI: val = ins.operand_a;
                OP_GTIR: val = DATA_W'(ins.operand_a > rb);
                OP_GTRI: val = DATA_W'(ra > ins.operand_b);
                OP_GTRR: val = DATA_W'(ra > rb);
                OP_EQIR: val = DATA_W'(ins.operand_a == rb);
                OP_EQRI: val = DATA_W'(ra == ins.operand_b);
                default: val = DATA_W'(ra == rb);
            endcase

            if (bad) val = '0;
            else     gpr[ins.dest_reg] = val;

            nip = mirror ? gpr[mirror_sel] + DATA_W'(1) : ip + DATA_W'(1);
            ip  = nip;

            r.next_ip       = nip;
            r.dest_index    = ins.dest_reg;
            r.written_value = val;
            r.halted        = (nip >= {{(DATA_W-PROG_LEN_W){1'b0}}, prog_len});
            r.bad_index     = bad;
            retirements.push_back(r);
        endfunction

        function void retire(logic [M_TDATA_W-1:0] td, logic tl, logic tu);
            t_retire r;
            if (retirements.size() == 0) begin
                $error("result transaction with none expected: next_ip=%h", td[31:0]);
                fail_count++;
                return;
            end
            r = retirements.pop_front();
            if (td[31:0] !== r.next_ip) begin
                $error("next_ip expected %h actual %h", r.next_ip, td[31:0]);
                fail_count++;
            end
            if (td[34:32] !== r.dest_index) begin
                $error("dest_index expected %0d actual %0d", r.dest_index, td[34:32]);
                fail_count++;
            end
            if (td[66:35] !== r.written_value) begin
                $error("written_value expected %h actual %h", r.written_value, td[66:35]);
                fail_count++;
            end
            if (tl !== r.halted) begin
                $error("halted expected %b actual %b", r.halted, tl);
                fail_count++;
            end
            if (tu !== r.bad_index) begin
                $error("bad_index expected %b actual %b", r.bad_index, tu);
                fail_count++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------- signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [3:0] opcode, [35:4] a, [67:36] b, [70:68] dest
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [31:0] next_ip, [34:32] dest, [66:35] value
    logic                  m_axis_tlast;   // halted
    logic                  m_axis_tuser;   // bad_index
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    retire_tracker sb;
    int  instr_offered;        // input transactions put on the bus (main process)
    int  instr_taken;          // input transactions accepted (monitor)
    int  hold_requests;        // long hold-offs asked for (main process)
    int  hold_served;          // long hold-offs started (receiver process)
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  cycle_count;

    six_register_machine_step u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates land. Results are checked before the new input is issued;
    // an input passes the instruction and result registers, so order does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.retire(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.issue(t_instr'(s_axis_tdata[INSTR_W-1:0]));
                instr_taken++;
            end
        end
    end

    // Receiver: one decision per falling edge. Short random stalls while
    // idling is on; a long hold-off, counted here, whenever one is asked for.
    initial begin
        int hold_left;
        hold_left     = 0;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served < hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
                hold_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Runaway guard
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- driving
    function automatic t_instr mk(t_opcode op, logic [DATA_W-1:0] a,
                                  logic [DATA_W-1:0] b, logic [DEST_W-1:0] d);
        t_instr ins;
        ins.opcode    = op;
        ins.operand_a = a;
        ins.operand_b = b;
        ins.dest_reg  = d;
        return ins;
    endfunction

    // Mostly valid register indexes (which double as small immediates), some
    // full-width noise and a few indexes just past the file.
    function automatic logic [DATA_W-1:0] rand_operand();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15)       return DATA_W'($urandom_range(0, REG_COUNT - 1));
        else if (pick < 18)  return $urandom();
        else if (pick == 18) return DATA_W'($urandom_range(REG_COUNT, 7));
        else                 return '1;
    endfunction

    function automatic t_instr rand_instr(logic [IP_REG_W-1:0] mirror_sel,
                                          logic [PROG_LEN_W-1:0] len);
        t_instr ins;
        // now and then a jump: load the mirror register with a pointer
        // around the program length so the halt flag toggles
        if (mirror_sel < REG_COUNT && $urandom_range(0, 24) == 0)
            return mk(OP_SETI, DATA_W'($urandom_range(0, int'(len) + 2)),
                      $urandom(), mirror_sel);
        ins.opcode    = t_opcode'($urandom_range(0, 15));
        ins.operand_a = rand_operand();
        ins.operand_b = rand_operand();
        ins.dest_reg  = ($urandom_range(0, 19) == 0) ? DEST_W'($urandom_range(6, 7))
                                                     : DEST_W'($urandom_range(0, 5));
        return ins;
    endfunction

    // Offers one instruction, starting and ending at a falling edge, and
    // returns once the transaction has been accepted.
    task automatic push_instr(input t_instr ins);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(ins);
        instr_offered++;
        while (instr_taken < instr_offered) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        while (sb.retirements.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Only touches the registers with the block idle
    task automatic reconfigure(input logic [IP_REG_W-1:0] mirror_sel,
                               input logic [PROG_LEN_W-1:0] len);
        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);
        write_cfg(CFG_IP_REGISTER, CFG_DATA_W'(mirror_sel));
        sb.set_mirror(mirror_sel);
        write_cfg(CFG_PROGRAM_LENGTH, len);
        sb.set_length(len);
    endtask

    // ---------------------------------------------------------------- main
    initial begin
        logic [IP_REG_W-1:0]   ph_mirror [NUM_PHASES];
        logic [PROG_LEN_W-1:0] ph_len    [NUM_PHASES];

        // Settings per phase: extremes of length, mirror slots 0, 1, 2, 3 and 5, and
        // one mirror index past the file (pointer then just counts).
        ph_mirror[0] = 3'd0; ph_len[0] = 16'hFFFF;
        ph_mirror[1] = 3'd5; ph_len[1] = 16'd1;
        ph_mirror[2] = 3'd3; ph_len[2] = 16'd40;
        ph_mirror[3] = 3'd7; ph_len[3] = 16'd200;
        ph_mirror[4] = 3'd1; ph_len[4] = 16'd300;
        ph_mirror[5] = 3'd2; ph_len[5] = 16'd25;

        sb            = new();
        instr_offered = 0;
        instr_taken   = 0;
        hold_requests = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed part, on the reset configuration (register 0 mirrors the
        // pointer, program length at its maximum).
        push_instr(mk(OP_SETI, 32'hFFFF_FFFF, 32'd0, 3'd1));
        push_instr(mk(OP_SETI, 32'h8000_0000, 32'd0, 3'd2));
        push_instr(mk(OP_ADDR, 32'd1, 32'd2, 3'd3));            // wraps
        push_instr(mk(OP_ADDI, 32'd1, 32'hFFFF_FFFF, 3'd4));
        push_instr(mk(OP_MULR, 32'd1, 32'd1, 3'd5));            // low half only
        push_instr(mk(OP_MULI, 32'd2, 32'd2, 3'd3));
        push_instr(mk(OP_BANR, 32'd1, 32'd2, 3'd4));
        push_instr(mk(OP_BANI, 32'd1, 32'h0F0F_0F0F, 3'd5));
        push_instr(mk(OP_BORR, 32'd2, 32'd3, 3'd4));
        push_instr(mk(OP_BORI, 32'd3, 32'hFFFF_FFFF, 3'd5));
        push_instr(mk(OP_SETR, 32'd1, 32'hFFFF_FFFF, 3'd2));    // b ignored
        push_instr(mk(OP_SETI, 32'hFFFF_FFFF, 32'd7, 3'd3));    // b ignored, a is the immediate
        push_instr(mk(OP_GTIR, 32'hFFFF_FFFF, 32'd1, 3'd4));
        push_instr(mk(OP_GTRI, 32'd1, 32'd0, 3'd5));
        push_instr(mk(OP_GTRR, 32'd2, 32'd1, 3'd4));
        push_instr(mk(OP_EQIR, 32'd0, 32'd0, 3'd5));            // reads the mirror
        push_instr(mk(OP_EQRI, 32'd1, 32'hFFFF_FFFF, 3'd4));
        push_instr(mk(OP_EQRR, 32'd1, 32'd1, 3'd5));
        push_instr(mk(OP_ADDR, 32'd6, 32'd1, 3'd3));            // bad first index
        push_instr(mk(OP_ADDR, 32'd1, 32'hFFFF_FFFF, 3'd3));    // bad second index
        push_instr(mk(OP_ADDI, 32'd2, 32'd7, 3'd6));            // bad destination
        push_instr(mk(OP_MULR, 32'd0, 32'd0, 3'd7));
        push_instr(mk(OP_GTIR, 32'hFFFF_FFFF, 32'd0, 3'd2));    // immediate not checked
        push_instr(mk(OP_SETI, 32'hFFFF_FFFE, 32'd0, 3'd0));    // jump far: halted
        push_instr(mk(OP_ADDI, 32'd0, 32'd0, 3'd1));            // pointer wraps to 0

        // Random phases. Each starts from a pointer of one where a register
        // mirrors it; phase 2 carries the long hold-off, the last has no idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            reconfigure(ph_mirror[p], ph_len[p]);
            tx_idle_en = (p != NUM_PHASES - 1);
            rx_idle_en = (p != NUM_PHASES - 1);
            if (p == 2) hold_requests++;
            if (ph_mirror[p] < REG_COUNT)
                push_instr(mk(OP_SETI, 32'd0, 32'd0, ph_mirror[p]));
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_instr(rand_instr(ph_mirror[p], ph_len[p]));
        end

        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);

        if (sb.fail_count == 0 && sb.retirements.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: six_register_machine_step.f
+incdir+rtl/core
rtl/core/srms_pkg.sv
rtl/core/six_register_machine_step.sv
rtl/core/srms_checker.sv
bench/tb_top.sv
